[rtl/least_loaded_server_dispatch_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the least-loaded server dispatcher.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef LEAST_LOADED_SERVER_DISPATCH_MACROS_SVH
`define LEAST_LOADED_SERVER_DISPATCH_MACROS_SVH

// Same-cycle implication
`define LLSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LLSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/llsd_pkg.sv]
// ---------------------------------------------------------------------------
// llsd_pkg
// Shared constants, types and pointer helpers for the dispatcher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package llsd_pkg;

  localparam int unsigned MAX_SERVERS   = 16;
  localparam int unsigned PENDING_DEPTH = 16;
  localparam int unsigned ARR_W  = 32;
  localparam int unsigned TIME_W = 33;
  localparam int unsigned CFG_W  = 5;
  localparam int unsigned SRV_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CNT_W  = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned PTR_W  = $clog2(PENDING_DEPTH);

  localparam logic [CFG_W-1:0] SERVERS_RESET = CFG_W'(16);

  // Best server seen so far, handed down the cell row
  typedef struct packed {
    logic [SRV_W-1:0]  idx;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] last;
  } cand_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              clear;
    logic              retire;
    logic              commit;
    logic [CFG_W-1:0]  used;
    logic [SRV_W-1:0]  sel;
    logic [ARR_W-1:0]  arrival;
    logic [TIME_W-1:0] finish;
  } cell_ctrl_t;

  // Per-cell status back to the sequencer
  typedef struct packed {
    logic             pop;
    logic [CNT_W-1:0] count;
  } cell_stat_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(PENDING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] prev_ptr(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(PENDING_DEPTH - 1) : p - PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

[rtl/llsd_if.sv]
// ---------------------------------------------------------------------------
// Dispatcher channel interfaces
// Job input, result output and configuration write channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface llsd_job_if;
  import llsd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ARR_W-1:0] arrival_time;
  logic [ARR_W-1:0] service_time;
  logic             new_batch;
  logic             last_job;

  modport source (output valid, arrival_time, service_time, new_batch, last_job,
                  input ready);
  modport sink   (input valid, arrival_time, service_time, new_batch, last_job,
                  output ready);
endinterface

interface llsd_res_if;
  import llsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [SRV_W-1:0]  server_index;
  logic [TIME_W-1:0] finish_time;
  logic [TIME_W-1:0] latest_finish;
  logic              pending_overflow;
  logic              batch_done;

  modport source (output valid, server_index, finish_time, latest_finish,
                  pending_overflow, batch_done, input ready);
  modport sink   (input valid, server_index, finish_time, latest_finish,
                  pending_overflow, batch_done, output ready);
endinterface

interface llsd_cfg_if;
  import llsd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] servers_in_use;

  modport source (output valid, servers_in_use, input ready);
  modport sink   (input valid, servers_in_use, output ready);
endinterface

`default_nettype wire

[rtl/llsd_cell.sv]
// ---------------------------------------------------------------------------
// llsd_cell
// One server: last finish, pending FIFO with retirement, and one stage of
// the least-loaded search chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module llsd_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [llsd_pkg::SRV_W-1:0] idx_i,
  input  llsd_pkg::cell_ctrl_t     ctrl_i,
  input  llsd_pkg::cand_t          cand_i,
  output llsd_pkg::cand_t          cand_o,
  output llsd_pkg::cell_stat_t     stat_o
);
  import llsd_pkg::*;

  logic [TIME_W-1:0] store_q [PENDING_DEPTH];
  logic [PTR_W-1:0]  head_q, tail_q;
  logic [CNT_W-1:0]  count_q;
  logic [TIME_W-1:0] last_q;
  cand_t             cand_q, cand_d;

  logic pop, sel, full, take_own;

  // Head retires when its finish is at or before the arrival
  assign pop  = ctrl_i.retire && (count_q != '0) &&
                (store_q[head_q] <= TIME_W'(ctrl_i.arrival));
  assign sel  = ctrl_i.commit && (ctrl_i.sel == idx_i);
  assign full = (count_q >= CNT_W'(PENDING_DEPTH));

  // FIFO control and last finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      last_q  <= '0;
    end else if (ctrl_i.clear) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      last_q  <= '0;
    end else if (pop) begin
      head_q  <= next_ptr(head_q);
      count_q <= count_q - CNT_W'(1);
    end else if (sel) begin
      last_q <= ctrl_i.finish;
      if (!full) begin
        tail_q  <= next_ptr(tail_q);
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  // FIFO storage; a full store overwrites its newest entry
  always_ff @(posedge clk_i) begin
    if (sel) begin
      if (full) begin
        store_q[prev_ptr(tail_q)] <= ctrl_i.finish;
      end else begin
        store_q[tail_q] <= ctrl_i.finish;
      end
    end
  end

  // Search stage: strict compare keeps the lower index on a tie
  always_comb begin
    take_own = (idx_i == '0) ||
               ((CFG_W'(idx_i) < ctrl_i.used) && (count_q < cand_i.count));
    cand_d = cand_i;
    if (take_own) begin
      cand_d.idx   = idx_i;
      cand_d.count = count_q;
      cand_d.last  = last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  assign cand_o       = cand_q;
  assign stat_o.pop   = pop;
  assign stat_o.count = count_q;

endmodule

`default_nettype wire

[rtl/least_loaded_server_dispatch.sv]
// ---------------------------------------------------------------------------
// least_loaded_server_dispatch
// Join-shortest-queue dispatcher built from a row of server cells.
// ---------------------------------------------------------------------------
// Usage:
//   job_i  : one transaction per job (arrival, service, new_batch, last_job).
//   res_o  : one transaction per job (server, finish, latest finish,
//            overflow flag, batch_done echo), in job order.
//   cfg_i  : writes servers_in_use; always ready, write only while idle.
// Timing:
//   A job is taken only when the sequencer is idle. Its cells then retire
//   pending entries one per server per cycle until no server retires (at
//   most 16 entries on any one server), then the search chain walks the
//   16 cells, the calculation state computes the finish and the commit
//   state loads the result register. A new job is taken only after the
//   previous one has committed.
// Reset: all server state and running latest clear at once, servers_in_use
//   returns to 16; no clearing pass.
// Stall: a held result sits in the output register while the next job
//   retires and searches; only the commit step waits for res_o.ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "least_loaded_server_dispatch_macros.svh"

module least_loaded_server_dispatch (
  input  logic       clk_i,
  input  logic       rst_ni,
  llsd_cfg_if.sink   cfg_i,
  llsd_job_if.sink   job_i,
  llsd_res_if.source res_o
);
  import llsd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RETIRE = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_CALC   = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  used_q, used_eff;
  logic [ARR_W-1:0]  arrival_q, service_q;
  logic              last_job_q;
  logic [SRV_W-1:0]  scnt_q;
  cand_t             best_q;
  logic [TIME_W-1:0] finish_q, running_q;

  logic              out_valid_q;
  logic [SRV_W-1:0]  out_idx_q;
  logic [TIME_W-1:0] out_finish_q, out_latest_q;
  logic              out_ovf_q, out_done_q;

  logic              accept, commit_fire, any_pop;
  logic [TIME_W-1:0] start, latest;
  logic [TIME_W:0]   sum;
  cell_ctrl_t        ctrl;
  cand_t             chain [MAX_SERVERS+1];
  cell_stat_t        stat  [MAX_SERVERS];
  logic [MAX_SERVERS-1:0]            pop_all;
  logic [MAX_SERVERS-1:0][CNT_W-1:0] cnt_all;

  // Configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= SERVERS_RESET;
    end else if (cfg_i.valid) begin
      used_q <= cfg_i.servers_in_use;
    end
  end

  always_comb begin
    if (used_q == '0) begin
      used_eff = CFG_W'(1);
    end else if (used_q > CFG_W'(MAX_SERVERS)) begin
      used_eff = CFG_W'(MAX_SERVERS);
    end else begin
      used_eff = used_q;
    end
  end

  // Handshakes
  assign job_i.ready = (state_q == ST_IDLE);
  assign accept      = job_i.valid && (state_q == ST_IDLE);
  assign commit_fire = (state_q == ST_COMMIT) && (!out_valid_q || res_o.ready);

  // Cell broadcast
  always_comb begin
    ctrl.clear   = accept && job_i.new_batch;
    ctrl.retire  = (state_q == ST_RETIRE);
    ctrl.commit  = commit_fire;
    ctrl.used    = used_eff;
    ctrl.sel     = best_q.idx;
    ctrl.arrival = arrival_q;
    ctrl.finish  = finish_q;
  end

  // Row of server cells
  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    llsd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SRV_W'(g)),
      .ctrl_i (ctrl),
      .cand_i (chain[g]),
      .cand_o (chain[g+1]),
      .stat_o (stat[g])
    );
    assign pop_all[g] = stat[g].pop;
    assign cnt_all[g] = stat[g].count;
  end

  assign any_pop = |pop_all;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_RETIRE;
      ST_RETIRE: if (!any_pop) state_d = ST_SEARCH;
      ST_SEARCH: if (scnt_q == SRV_W'(MAX_SERVERS - 1)) state_d = ST_CALC;
      ST_CALC:   state_d = ST_COMMIT;
      ST_COMMIT: if (commit_fire) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SEARCH) begin
        scnt_q <= scnt_q + SRV_W'(1);
      end else begin
        scnt_q <= '0;
      end
    end
  end

  // Finish time: later of server free and arrival, plus service, saturated
  assign start = (best_q.last > TIME_W'(arrival_q)) ? best_q.last : TIME_W'(arrival_q);
  assign sum   = (TIME_W+1)'(start) + (TIME_W+1)'(service_q);
  assign latest = (finish_q > running_q) ? finish_q : running_q;

  // Job payload and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      arrival_q  <= job_i.arrival_time;
      service_q  <= job_i.service_time;
      last_job_q <= job_i.last_job;
    end
    if ((state_q == ST_SEARCH) && (scnt_q == SRV_W'(MAX_SERVERS - 1))) begin
      best_q <= chain[MAX_SERVERS];
    end
    if (state_q == ST_CALC) begin
      finish_q <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    end
  end

  // Running latest finish of the batch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
    end else if (accept && job_i.new_batch) begin
      running_q <= '0;
    end else if (commit_fire) begin
      running_q <= latest;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_fire) begin
      out_idx_q    <= best_q.idx;
      out_finish_q <= finish_q;
      out_latest_q <= latest;
      out_ovf_q    <= (best_q.count >= CNT_W'(PENDING_DEPTH));
      out_done_q   <= last_job_q;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.server_index     = out_idx_q;
  assign res_o.finish_time      = out_finish_q;
  assign res_o.latest_finish    = out_latest_q;
  assign res_o.pending_overflow = out_ovf_q;
  assign res_o.batch_done       = out_done_q;

  // Checks
  `LLSD_ASSERT_IMP(a_latest_covers_finish, res_o.valid, res_o.latest_finish >= res_o.finish_time, "latest finish below job finish")
  `LLSD_ASSERT_IMP(a_finish_after_arrival, state_q == ST_COMMIT, finish_q >= TIME_W'(arrival_q), "finish before arrival")
  `LLSD_ASSERT_NXT(a_search_counts_frozen, state_q == ST_SEARCH, $stable(cnt_all), "pending counts moved during search")
  `LLSD_ASSERT_IMP(a_choice_in_use, $rose(res_o.valid), CFG_W'(res_o.server_index) < used_eff, "server chosen outside those in use")

endmodule

`default_nettype wire

[verif/llsd_dispatch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llsd_dispatch_checker
// Watches the job, result and configuration channels of the least-loaded
// dispatcher. It predicts each job's server, finish time, batch latest finish
// and flags, then compares every result transaction against the oldest
// prediction.
// ----------------------------------------------------------------------------
module llsd_dispatch_checker
  import llsd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  llsd_cfg_if  cfg,
  llsd_job_if  job,
  llsd_res_if  res,
  output int   fail_count_o,
  output int   outstanding_o,
  output int   checked_o,
  output int   overflow_o,
  output int   saturated_o
);

  localparam logic [TIME_W-1:0] TIME_SAT = '1;

  typedef struct packed {
    logic [SRV_W-1:0]  server;
    logic [TIME_W-1:0] finish;
    logic [TIME_W-1:0] latest;
    logic              overflow;
    logic              done;
  } dispatch_t;

  // Predicted server state
  logic [CFG_W-1:0]  servers_cfg;
  logic [TIME_W-1:0] last_finish  [MAX_SERVERS];
  logic [TIME_W-1:0] queue_finish [MAX_SERVERS][PENDING_DEPTH];
  int unsigned       queue_len    [MAX_SERVERS];
  logic [TIME_W-1:0] batch_latest;

  dispatch_t awaited_q [$];
  int        fails     = 0;
  int        checked   = 0;
  int        overflows = 0;
  int        saturated = 0;

  function automatic void clear_batch();
    for (int s = 0; s < MAX_SERVERS; s++) begin
      last_finish[s] = '0;
      queue_len[s]   = 0;
    end
    batch_latest = '0;
  endfunction

  // Retire, pick the shortest queue, book the job on it
  function automatic dispatch_t dispatch_job(input logic [ARR_W-1:0] arrival,
                                             input logic [ARR_W-1:0] service,
                                             input logic             fresh,
                                             input logic             last);
    dispatch_t         r;
    int unsigned       used;
    int unsigned       best;
    int unsigned       k;
    logic [TIME_W-1:0] start;
    logic [TIME_W:0]   sum;

    if (fresh) clear_batch();

    // every server retires, in use or not; stores are sorted so it's a prefix
    for (int s = 0; s < MAX_SERVERS; s++) begin
      k = 0;
      while (k < queue_len[s] && queue_finish[s][k] <= {1'b0, arrival}) k++;
      for (int j = k; j < queue_len[s]; j++) queue_finish[s][j-k] = queue_finish[s][j];
      queue_len[s] -= k;
    end

    used = 32'(servers_cfg);
    if (used < 1) used = 1;
    if (used > MAX_SERVERS) used = MAX_SERVERS;

    best = 0;
    for (int s = 1; s < used; s++) begin
      if (queue_len[s] < queue_len[best]) best = s;
    end

    start = last_finish[best];
    if ({1'b0, arrival} > start) start = {1'b0, arrival};
    sum = {1'b0, start} + {2'b00, service};
    r.finish = sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];
    last_finish[best] = r.finish;

    // full store: newest entry replaced, count pinned
    r.overflow = (queue_len[best] >= PENDING_DEPTH);
    if (r.overflow) begin
      queue_finish[best][PENDING_DEPTH-1] = r.finish;
    end else begin
      queue_finish[best][queue_len[best]] = r.finish;
      queue_len[best]++;
    end

    if (r.finish > batch_latest) batch_latest = r.finish;
    r.server = SRV_W'(best);
    r.latest = batch_latest;
    r.done   = last;
    return r;
  endfunction

  function automatic void check_field(input string             name,
                                      input logic [TIME_W-1:0] want,
                                      input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  // Sample all channels on the clock; results before jobs keeps queue order
  always @(posedge clk_i or negedge rst_ni) begin
    dispatch_t want;
    if (!rst_ni) begin
      servers_cfg = SERVERS_RESET;
      clear_batch();
      awaited_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) servers_cfg = cfg.servers_in_use;

      if (res.valid && res.ready) begin
        if (awaited_q.size() == 0) begin
          $error("result transaction with no job outstanding: server_index %0d",
                 res.server_index);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          check_field("server_index", TIME_W'(want.server), TIME_W'(res.server_index));
          check_field("finish_time", want.finish, res.finish_time);
          check_field("latest_finish", want.latest, res.latest_finish);
          check_field("pending_overflow", TIME_W'(want.overflow),
                      TIME_W'(res.pending_overflow));
          check_field("batch_done", TIME_W'(want.done), TIME_W'(res.batch_done));
          checked++;
        end
      end

      if (job.valid && job.ready) begin
        want = dispatch_job(job.arrival_time, job.service_time, job.new_batch,
                            job.last_job);
        if (want.overflow) overflows++;
        if (want.finish == TIME_SAT) saturated++;
        awaited_q.push_back(want);
      end
    end
    fail_count_o  <= fails;
    outstanding_o <= awaited_q.size();
    checked_o     <= checked;
    overflow_o    <= overflows;
    saturated_o   <= saturated;
  end

endmodule

[verif/tb_least_loaded_server_dispatch.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_least_loaded_server_dispatch
// Drives jobs and server-count writes into the dispatcher with random gaps
// and result back-pressure, including one long hold-off that fills the block.
// A directed opener covers field extremes, backwards arrivals, saturation and
// a full pending store; random batches under several server counts follow.
// ----------------------------------------------------------------------------
module tb_least_loaded_server_dispatch;
  import llsd_pkg::*;

  localparam int CYCLE_LIMIT  = 600_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 12;
  localparam int PHASE_JOBS   = 140;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  llsd_job_if job_ch ();
  llsd_res_if res_ch ();
  llsd_cfg_if cfg_ch ();

  logic calm       = 1'b0;
  logic hold_armed = 1'b0;
  logic hold_used  = 1'b0;
  int   hold_left  = 0;
  int   cycles     = 0;
  int   jobs_sent  = 0;
  int   cfg_writes = 0;

  int fail_count;
  int outstanding;
  int checked;
  int overflows;
  int saturated;

  always #4 clk = ~clk;

  least_loaded_server_dispatch dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .job_i  (job_ch),
    .res_o  (res_ch)
  );

  llsd_dispatch_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg           (cfg_ch),
    .job           (job_ch),
    .res           (res_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .overflow_o    (overflows),
    .saturated_o   (saturated)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off once armed
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_armed && !hold_used) begin
      hold_used    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm || ($urandom_range(99) >= 14);
    end
  end

  // One job transaction, with an occasional gap in front
  task automatic send_job(input logic [ARR_W-1:0] arrival,
                          input logic [ARR_W-1:0] service,
                          input logic             fresh,
                          input logic             last);
    if (!calm && $urandom_range(99) < 14) begin
      job_ch.valid <= 1'b0;
      repeat ($urandom_range(40, 1)) @(posedge clk);
    end
    job_ch.valid        <= 1'b1;
    job_ch.arrival_time <= arrival;
    job_ch.service_time <= service;
    job_ch.new_batch    <= fresh;
    job_ch.last_job     <= last;
    @(posedge clk);
    while (!job_ch.ready) @(posedge clk);
    jobs_sent++;
  endtask

  // Server count only changes once every job has come back
  task automatic write_servers(input logic [CFG_W-1:0] value);
    job_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.servers_in_use <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  // Random batches: mostly ordered arrivals, some noise that breaks order
  task automatic run_batches(input int count);
    int               sent;
    int               len;
    int               pick;
    logic [ARR_W-1:0] now;
    logic [ARR_W-1:0] service;
    logic             fresh;
    logic             last;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(24, 1);
      now = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1000);
      for (int j = 0; j < len && sent < count; j++) begin
        pick = $urandom_range(99);
        if (pick < 50)      now += $urandom_range(5);
        else if (pick < 85) now += $urandom_range(30);
        else if (pick < 97) now += $urandom_range(1000);
        else                now += $urandom() >> 4;

        pick = $urandom_range(99);
        if (pick < 70)      service = $urandom_range(60);
        else if (pick < 90) service = $urandom_range(400);
        else if (pick < 97) service = $urandom();
        else                service = ($urandom_range(1) != 0) ? '1 : '0;

        fresh = (j == 0);
        last  = (j == len - 1);
        // noise: out-of-order arrival or stray batch flags
        if ($urandom_range(99) < 8) begin
          if ($urandom_range(1) != 0) now = $urandom();
          fresh = 1'($urandom_range(1));
          last  = 1'($urandom_range(1));
        end
        send_job(now, service, fresh, last);
        sent++;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] servers;

    job_ch.valid          = 1'b0;
    job_ch.arrival_time   = '0;
    job_ch.service_time   = '0;
    job_ch.new_batch      = 1'b0;
    job_ch.last_job       = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.servers_in_use = '0;
    res_ch.ready          = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes under the reset server count
    send_job('0, '0, 1'b1, 1'b0);
    send_job('0, '1, 1'b0, 1'b0);
    send_job(32'd5, 32'd10, 1'b0, 1'b0);
    send_job('1, '1, 1'b0, 1'b1);
    send_job(32'd100, 32'd7, 1'b1, 1'b0);
    // arrival going backwards
    send_job(32'd40, 32'd3, 1'b0, 1'b1);

    // One server: finish climbs to the ceiling, store fills then overflows
    write_servers(CFG_W'(1));
    for (int j = 0; j < PENDING_DEPTH + 2; j++) begin
      send_job('0, '1, j == 0, j == PENDING_DEPTH + 1);
    end

    // Random phases over a spread of server counts
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: servers = '0;
        1: servers = '1;
        2: servers = CFG_W'(MAX_SERVERS);
        3: servers = CFG_W'(1);
        4: servers = CFG_W'(2);
        default: servers = CFG_W'($urandom_range(31));
      endcase
      write_servers(servers);
      hold_armed <= (p >= 2);
      calm       <= (p == 4);
      run_batches(PHASE_JOBS);
    end

    job_ch.valid <= 1'b0;
    calm         <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d jobs over %0d server-count writes, %0d results compared",
             jobs_sent, cfg_writes, checked);
    $display("Summary: %0d jobs hit a full pending store, %0d finish times saturated",
             overflows, saturated);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
